### hdl/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define DQ_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dq assertion failed");

// Next-cycle implication, disabled during reset.
`define DQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dq assertion failed");

`else

`define DQ_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define DQ_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Transaction payload types, request and status codes, controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dq_pkg;

    // Request codes
    localparam logic [1:0] OP_PUSH      = 2'd0;
    localparam logic [1:0] OP_POP_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_BACK  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] push_value;
    } dq_in_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } dq_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic execute;   // update pointers, access the store
        logic publish;   // load the result register
    } dq_cmd_t;

endpackage

### hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one request through execute and load, owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module dq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output dq_pkg::dq_cmd_t cmd
);
    import dq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;

    // Take a new request once the controller is idle and the result register is empty or draining.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    assign cmd.capture = accept;
    assign cmd.execute = (state_reg == ST_EXEC);
    assign cmd.publish = (state_reg == ST_LOAD);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `DQ_ASSERT_IMPLIES(a_load_into_free, aclk, aresetn, state_reg == ST_LOAD, !m_valid_reg)
    `DQ_ASSERT_NEXT(a_load_shows_result, aclk, aresetn, state_reg == ST_LOAD, m_valid_reg)
    `DQ_ASSERT_IMPLIES(a_exec_after_accept, aclk, aresetn, state_reg == ST_EXEC, $past(accept))

endmodule

### hdl/dq_datapath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Circular store, head and tail pointers, count and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  dq_pkg::dq_cmd_t cmd,
    input  dq_pkg::dq_in_t  s_data,
    output dq_pkg::dq_out_t m_data
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic signed [31:0] mem [DEPTH];

    dq_in_t             req_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         stat_reg, stat_next;
    logic               pop_ok_reg, pop_ok_next;
    logic signed [31:0] rd_data_reg;
    dq_out_t            out_reg;

    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_addr;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      tail_inc;
    logic [AW-1:0]      tail_dec;
    logic               is_full;
    logic               is_empty;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        stat_next   = stat_reg;
        pop_ok_next = pop_ok_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = tail_reg;
        if (cmd.execute) begin
            stat_next   = STAT_OK;
            pop_ok_next = 1'b0;
            unique case (req_reg.opcode)
                OP_PUSH: begin
                    if (is_full) begin
                        stat_next = STAT_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        mem_addr   = tail_reg;
                        tail_next  = tail_inc;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty) begin
                        stat_next = STAT_EMPTY;
                    end else begin
                        mem_re      = 1'b1;
                        mem_addr    = head_reg;
                        head_next   = head_inc;
                        count_next  = count_reg - 1'b1;
                        pop_ok_next = 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (is_empty) begin
                        stat_next = STAT_EMPTY;
                    end else begin
                        mem_re      = 1'b1;
                        mem_addr    = tail_dec;
                        tail_next   = tail_dec;
                        count_next  = count_reg - 1'b1;
                        pop_ok_next = 1'b1;
                    end
                end
                default: begin
                    // unused code: leave the queue alone
                end
            endcase
        end
    end

    // Store: one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= req_reg.push_value;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        stat_reg   <= stat_next;
        pop_ok_reg <= pop_ok_next;
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.publish) begin
            out_reg.pop_value <= pop_ok_reg ? rd_data_reg : 32'sd0;
            out_reg.status    <= stat_reg;
            out_reg.occupancy <= 5'(count_reg);
        end
    end

    assign m_data = out_reg;

endmodule

### hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed words: push back, pop front, pop back.
// ----------------------------------------------------------------------------
// Each transaction passes three steps from acceptance to result: the
// request is latched, the pointers move and the single-port store is
// accessed, and the registered read data reaches the result register.
// A new request is taken as soon as the previous one is in the result
// register and that register is empty or being drained, so the block
// takes no new request while one is still in flight. The store needs no
// clearing after reset; the queue is ready as soon as reset is released.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dq_pkg::dq_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dq_pkg::dq_out_t m_data
);
    import dq_pkg::*;

    dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

### test/deque_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Watches both channels, predicts each result from the accepted requests
// and compares every returned result field by field against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  dq_pkg::dq_in_t  s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  dq_pkg::dq_out_t m_data,
    output int              fail_count,
    output int              outstanding
);

    import dq_pkg::*;

    logic signed [31:0] stored_words [DEPTH];
    int                 front_slot;
    int                 back_slot;
    int                 word_count;
    int                 errors;
    dq_out_t            awaited_results [$];

    // Apply one request to the shadow deque and return the result it yields.
    function automatic dq_out_t serve_request(dq_in_t req);
        dq_out_t res;
        res.pop_value = '0;
        res.status    = STAT_OK;
        case (req.opcode)
            OP_PUSH: begin
                if (word_count >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    stored_words[back_slot] = req.push_value;
                    back_slot  = (back_slot + 1) % DEPTH;
                    word_count = word_count + 1;
                end
            end
            OP_POP_FRONT: begin
                if (word_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.pop_value = stored_words[front_slot];
                    front_slot = (front_slot + 1) % DEPTH;
                    word_count = word_count - 1;
                end
            end
            OP_POP_BACK: begin
                if (word_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    back_slot = (back_slot + DEPTH - 1) % DEPTH;
                    res.pop_value = stored_words[back_slot];
                    word_count = word_count - 1;
                end
            end
            default: begin
                // unused code: leave the deque untouched
            end
        endcase
        res.occupancy = word_count[4:0];
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        dq_out_t want;
        if (!aresetn) begin
            front_slot = 0;
            back_slot  = 0;
            word_count = 0;
            errors     = 0;
            awaited_results.delete();
        end else begin
            // record the prediction first so a same-edge result still finds it
            if (s_valid && s_ready)
                awaited_results.push_back(serve_request(s_data));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: pop_value %0d status %0d occupancy %0d",
                           m_data.pop_value, m_data.status, m_data.occupancy);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.pop_value !== want.pop_value) begin
                        $error("pop_value: expected %0d, got %0d",
                               want.pop_value, m_data.pop_value);
                        errors++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        errors++;
                    end
                    if (m_data.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, m_data.occupancy);
                        errors++;
                    end
                end
            end
        end
        fail_count  <= errors;
        outstanding <= awaited_results.size();
    end

endmodule

### test/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives directed and biased random push / pop requests through the deque
// under varying backpressure and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_double_ended_queue;

    import dq_pkg::*;

    localparam int         DEPTH        = 16;
    localparam int         PHASE_ITEMS  = 600;
    localparam int         STALL_CYCLES = 200;
    localparam int         DRAIN_CYCLES = 20;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    dq_in_t  s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    dq_out_t m_data;

    int fail_count;
    int outstanding;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit stall_armed   = 1'b0;

    always #5 aclk = ~aclk;

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    deque_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Offer one transaction, idling first at the current rate, and hold it
    // until the deque takes it.
    task automatic send_request(input logic [1:0] op, input logic signed [31:0] word);
        dq_in_t req;
        req.opcode     = op;
        req.push_value = word;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_opcode(int push_pct);
        if ($urandom_range(99) < 5)
            return OP_RESERVED;
        if ($urandom_range(99) < push_pct)
            return OP_PUSH;
        return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // Bursts lean toward pushing or popping so the fill level sweeps from
    // empty to full and both refusal cases come up often.
    task automatic run_random(input int count);
        int burst_left;
        int push_pct;
        burst_left = 0;
        push_pct   = 50;
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 40);
                case ($urandom_range(2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            burst_left--;
            send_request(pick_opcode(push_pct), pick_word());
        end
    endtask

    // Result side: random backpressure plus one long hold-off on request.
    initial begin : sink
        bit stall_taken;
        stall_taken = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (stall_armed && !stall_taken) begin
                stall_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 33;
        sink_idle_pct = 88;

        // empty deque: both pops refused, unused code ignored
        send_request(OP_POP_FRONT, 32'sd5);
        send_request(OP_POP_BACK, -32'sd5);
        send_request(OP_RESERVED, 32'sh7FFF_FFFF);
        // fill to the brim with extreme and random words
        send_request(OP_PUSH, 32'sh7FFF_FFFF);
        send_request(OP_PUSH, 32'sh8000_0000);
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, '1);
        repeat (DEPTH - 4) send_request(OP_PUSH, $urandom);
        // full deque: push refused, unused code ignored, then a pop from each end
        send_request(OP_PUSH, 32'sh1234_5678);
        send_request(OP_RESERVED, 32'sh8000_0000);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_BACK, '0);

        run_random(PHASE_ITEMS);

        src_idle_pct  = 88;
        sink_idle_pct = 33;
        run_random(PHASE_ITEMS);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_armed   = 1'b1;
        run_random(PHASE_ITEMS);
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
